[hw/rtl/nbvs_pkg.sv]
// Shared constants and types for the nearest beacon vote selector.
`default_nettype none

package nbvs_pkg;

  localparam int NODE_COUNT_DEF  = 16;
  localparam int RING_LENGTH_DEF = 10;
  localparam int CHANNEL_COUNT   = 3;
  localparam int FIRST_CHANNEL   = 37;

  localparam int CHAN_W     = 6;
  localparam int ADDR_IN_W  = 16;
  localparam int RSSI_W     = 8;
  localparam int OUT_W      = 4;
  localparam int STAMP_W    = 32;
  localparam int ENTRY_W    = RSSI_W + STAMP_W;
  localparam int CH_IDX_W   = 2;

  localparam int WINDOW_W   = 10;
  localparam int THRESH_W   = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_STALE_WINDOW   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOTE_THRESHOLD = 1'd1;

  localparam logic [WINDOW_W-1:0] STALE_WINDOW_RESET   = 10'd50;
  localparam logic [THRESH_W-1:0] VOTE_THRESHOLD_RESET = 4'd8;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic push;
    logic count_start;
    logic count_step;
  } ring_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/nbvs_if.sv]
// Handshake channels for beacon report items and published address items.
`default_nettype none

interface nbvs_in_if;
  import nbvs_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        from_loopback;
  logic [CHAN_W-1:0]           adv_channel;
  logic [ADDR_IN_W-1:0]        sender_address;
  logic signed [RSSI_W-1:0]    signal_strength;

  modport source (output valid, from_loopback, adv_channel, sender_address,
                  signal_strength, input ready);
  modport sink (input valid, from_loopback, adv_channel, sender_address,
                signal_strength, output ready);
endinterface

interface nbvs_out_if;
  import nbvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] nearest_address;

  modport source (output valid, nearest_address, input ready);
  modport sink (input valid, nearest_address, output ready);
endinterface

`default_nettype wire

[hw/rtl/nbvs_table_mem.sv]
// Single-port-write, single-port-read RAM holding strength and stamp per entry.
`default_nettype none

module nbvs_table_mem
  import nbvs_pkg::*;
#(
  parameter int DEPTH = CHANNEL_COUNT * NODE_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [AW-1:0]      waddr_i,
  input  wire logic [ENTRY_W-1:0] wdata_i,
  input  wire logic               re_i,
  input  wire logic [AW-1:0]      raddr_i,
  output      logic [ENTRY_W-1:0] rdata_o
);

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/nbvs_ring.sv]
// Ring of winning addresses with a vote counter that checks one entry per cycle while count_step is high.
`default_nettype none

module nbvs_ring
  import nbvs_pkg::*;
#(
  parameter int RING_LENGTH = RING_LENGTH_DEF,
  parameter int NODE_W      = 4,
  parameter int VOTE_W      = $clog2(RING_LENGTH + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ring_cmd_t         cmd_i,
  input  wire logic [NODE_W-1:0] node_i,
  output      logic [VOTE_W-1:0] votes_o,
  output      logic              done_o
);

  localparam int RIW = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;
  localparam logic [RIW-1:0] LAST = RIW'(RING_LENGTH - 1);

  logic [NODE_W-1:0] ring_q [RING_LENGTH];
  logic [RIW-1:0]    pos_q;
  logic [RIW-1:0]    idx_q;
  logic [VOTE_W-1:0] votes_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RING_LENGTH; i++) begin
        ring_q[i] <= '0;
      end
      pos_q   <= '0;
      idx_q   <= '0;
      votes_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        ring_q[pos_q] <= node_i;
        pos_q         <= (pos_q == LAST) ? '0 : pos_q + 1'b1;
      end
      if (cmd_i.count_start) begin
        idx_q   <= '0;
        votes_q <= '0;
        done_q  <= 1'b0;
      end else if (cmd_i.count_step && !done_q) begin
        if (ring_q[idx_q] == node_i) begin
          votes_q <= votes_q + 1'b1;
        end
        if (idx_q == LAST) begin
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  assign votes_o = votes_q;
  assign done_o  = done_q;

endmodule

`default_nettype wire

[hw/rtl/nearest_beacon_vote_selector.sv]
// Top-level sequencer: walks the reading table per stored report, the ring if it wins.
// A winning report goes through write, sweep, push, count and decide states.
// A report that does not vote returns to idle after push; a dropped one is never stored.
// The table sweep reads one RAM entry per cycle; the ring count reads one slot per cycle.
// After reset a clearing pass zeroes every table entry before input opens.
// Reset is asynchronous and active low; control registers return to their reset values.
`default_nettype none

module nearest_beacon_vote_selector
  import nbvs_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int RING_LENGTH = RING_LENGTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  nbvs_in_if.sink                    in_i,
  nbvs_out_if.source                 out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH  = CHANNEL_COUNT * NODE_COUNT;
  localparam int AW     = $clog2(DEPTH);
  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int VOTE_W = $clog2(RING_LENGTH + 1);
  localparam logic [AW-1:0]     LAST_ENTRY = AW'(DEPTH - 1);
  localparam logic [NODE_W-1:0] LAST_NODE  = NODE_W'(NODE_COUNT - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WRITE  = 3'd2;
  localparam logic [2:0] ST_SWEEP  = 3'd3;
  localparam logic [2:0] ST_PUSH   = 3'd4;
  localparam logic [2:0] ST_COUNT  = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;

  logic [2:0] state_q, state_d;

  logic [WINDOW_W-1:0] window_q;
  logic [THRESH_W-1:0] thresh_q;

  logic [NODE_W-1:0]        node_q;
  logic [CH_IDX_W-1:0]      ch_q;
  logic signed [RSSI_W-1:0] rssi_q;
  logic [AW-1:0]            ent_q;

  logic [STAMP_W-1:0] cnt_q;
  logic [STAMP_W-1:0] limit_q;
  logic               stale_en_q;
  logic               best_q;

  logic [AW-1:0]       sw_addr_q;
  logic [NODE_W-1:0]   sw_node_q;
  logic [CH_IDX_W-1:0] sw_ch_q;
  logic                sw_done_q;
  logic                tag_v_q;
  logic [AW-1:0]       tag_addr_q;
  logic                tag_row_q;

  logic               pub_valid_q;
  logic [NODE_W-1:0]  pub_node_q;
  logic               out_valid_q;
  logic [OUT_W-1:0]   out_data_q;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [ENTRY_W-1:0] mem_rdata;

  ring_cmd_t         ring_cmd;
  logic [VOTE_W-1:0] votes;
  logic              ring_done;

  logic                in_acc;
  logic                drop;
  logic [CH_IDX_W-1:0] in_ch;
  logic [STAMP_W-1:0]  cnt_nx;
  logic                rd_stale;
  logic                rd_beats;
  logic                publish;
  logic                pub_go;

  nbvs_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (sw_addr_q),
    .rdata_o (mem_rdata)
  );

  nbvs_ring #(
    .RING_LENGTH (RING_LENGTH),
    .NODE_W      (NODE_W),
    .VOTE_W      (VOTE_W)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (ring_cmd),
    .node_i  (node_q),
    .votes_o (votes),
    .done_o  (ring_done)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_ch      = CH_IDX_W'(in_i.adv_channel - CHAN_W'(FIRST_CHANNEL));
  assign drop       = in_i.from_loopback
                   || (in_i.sender_address == ADDR_IN_W'(1))
                   || (in_i.adv_channel < CHAN_W'(FIRST_CHANNEL))
                   || (in_i.adv_channel >= CHAN_W'(FIRST_CHANNEL + CHANNEL_COUNT))
                   || (in_i.sender_address >= ADDR_IN_W'(NODE_COUNT));

  assign cnt_nx = (cnt_q == STAMP_MAX) ? cnt_q : cnt_q + 1'b1;

  assign rd_stale = tag_v_q && stale_en_q && (mem_rdata[STAMP_W-1:0] < limit_q);
  assign rd_beats = tag_v_q && tag_row_q && !rd_stale
                 && (mem_rdata[ENTRY_W-1:STAMP_W] != '0)
                 && ($signed(mem_rdata[ENTRY_W-1:STAMP_W]) > rssi_q);

  assign publish = (8'(votes) >= 8'(thresh_q))
                && (!pub_valid_q || (pub_node_q != node_q));
  assign pub_go  = (state_q == ST_DECIDE) && publish && (!out_valid_q || out_o.ready);

  assign mem_re = (state_q == ST_SWEEP) && !sw_done_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = tag_addr_q;
    mem_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sw_addr_q;
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = ent_q;
        mem_wdata = {rssi_q, cnt_nx};
      end
      ST_SWEEP: begin
        mem_we = rd_stale;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    ring_cmd             = '0;
    ring_cmd.push        = (state_q == ST_PUSH) && best_q;
    ring_cmd.count_start = (state_q == ST_PUSH) && best_q;
    ring_cmd.count_step  = (state_q == ST_COUNT);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sw_addr_q == LAST_ENTRY) state_d = ST_IDLE;
      ST_IDLE:   if (in_acc && !drop) state_d = ST_WRITE;
      ST_WRITE:  state_d = ST_SWEEP;
      ST_SWEEP:  if (sw_done_q) state_d = ST_PUSH;
      ST_PUSH:   state_d = best_q ? ST_COUNT : ST_IDLE;
      ST_COUNT:  if (ring_done) state_d = ST_DECIDE;
      ST_DECIDE: if (!publish || pub_go) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      window_q    <= STALE_WINDOW_RESET;
      thresh_q    <= VOTE_THRESHOLD_RESET;
      cnt_q       <= '0;
      limit_q     <= '0;
      stale_en_q  <= 1'b0;
      best_q      <= 1'b0;
      sw_addr_q   <= '0;
      sw_node_q   <= '0;
      sw_ch_q     <= '0;
      sw_done_q   <= 1'b0;
      tag_v_q     <= 1'b0;
      pub_valid_q <= 1'b0;
      pub_node_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_STALE_WINDOW:   window_q <= cfg_data_i[WINDOW_W-1:0];
          CFG_VOTE_THRESHOLD: thresh_q <= cfg_data_i[THRESH_W-1:0];
          default:            ;
        endcase
      end

      tag_v_q <= mem_re;

      unique case (state_q)
        ST_CLEAR: begin
          sw_addr_q <= (sw_addr_q == LAST_ENTRY) ? '0 : sw_addr_q + 1'b1;
        end
        ST_WRITE: begin
          cnt_q      <= cnt_nx;
          limit_q    <= cnt_nx - STAMP_W'(window_q);
          stale_en_q <= cnt_nx > STAMP_W'(window_q);
          best_q     <= 1'b1;
          sw_addr_q  <= '0;
          sw_node_q  <= '0;
          sw_ch_q    <= '0;
          sw_done_q  <= 1'b0;
        end
        ST_SWEEP: begin
          if (rd_beats) begin
            best_q <= 1'b0;
          end
          if (mem_re) begin
            sw_done_q <= (sw_addr_q == LAST_ENTRY);
            sw_addr_q <= sw_addr_q + 1'b1;
            if (sw_node_q == LAST_NODE) begin
              sw_node_q <= '0;
              sw_ch_q   <= sw_ch_q + 1'b1;
            end else begin
              sw_node_q <= sw_node_q + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase

      if (pub_go) begin
        pub_valid_q <= 1'b1;
        pub_node_q  <= node_q;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      node_q <= NODE_W'(in_i.sender_address);
      ch_q   <= in_ch;
      rssi_q <= in_i.signal_strength;
      ent_q  <= AW'(32'(in_ch) * NODE_COUNT + 32'(in_i.sender_address[NODE_W-1:0]));
    end
    if (mem_re) begin
      tag_addr_q <= sw_addr_q;
      tag_row_q  <= (sw_ch_q == ch_q) && (sw_node_q >= NODE_W'(2));
    end
    if (pub_go) begin
      out_data_q <= OUT_W'(node_q);
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.nearest_address = out_data_q;

endmodule

`default_nettype wire
